### hdl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, widths, codes and the switching table of the sliding mode
// controller.
// ----------------------------------------------------------------------------
package smc_pkg;

	// Field widths
	localparam int ERR_W   = 32;  // error sample, Q16.16
	localparam int GAIN_W  = 24;  // gains, unsigned Q8.16
	localparam int VE_W    = ERR_W + 1;
	localparam int S_W     = 42;  // sliding surface, Q.16
	localparam int A_W     = GAIN_W + 1;
	localparam int B_W     = 34;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 54;
	localparam int T_W     = 18;  // table value, signed, |t| <= 1.0
	localparam int FRAC_W  = 20;  // interpolation fraction
	localparam int Q_SHIFT = 16;

	// Switching table
	localparam int TANH_TABLE_ENTRIES = 256;
	localparam int IDX_W = $clog2(TANH_TABLE_ENTRIES + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_SLOPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCHING_GAIN = 2'd2;

	localparam logic [GAIN_W-1:0] SURFACE_SLOPE_RST  = 24'd65536;
	localparam logic [GAIN_W-1:0] SURFACE_GAIN_RST   = 24'd65536;
	localparam logic [GAIN_W-1:0] SWITCHING_GAIN_RST = 24'd0;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic signed [VE_W-1:0]  ve_t;
	typedef logic signed [S_W-1:0]   surf_t;
	typedef logic signed [A_W-1:0]   mul_a_t;
	typedef logic signed [B_W-1:0]   mul_b_t;
	typedef logic signed [P_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [T_W-1:0]   tanh_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [FRAC_W-1:0]       frac_t;
	typedef logic [GAIN_W-1:0]       gain_t;

	typedef tanh_t tanh_rom_t [0:TANH_TABLE_ENTRIES];

	// Request to the shared multiplier
	typedef struct packed {
		logic   en;
		mul_a_t a;
		mul_b_t b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LE,   // lambda * e
		ST_MUL_LV,   // form S, lambda * ve
		ST_MUL_KH,   // ks * integer part of S
		ST_MUL_KL,   // ks * fraction of S
		ST_MUL_POS,  // table position of |S|
		ST_RD_LO,
		ST_RD_HI,
		ST_MUL_IP,   // interpolation product
		ST_SIGN,
		ST_MUL_ET,   // eps * tanh
		ST_SUM,
		ST_DONE
	} smc_state_t;

	// Floored quotient of two non-negative values by shift and subtract.
	function automatic longint div_pos(input longint num, input longint den);
		longint quo;
		longint rem;
		quo = 0;
		rem = 0;
		for (int b = 62; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & longint'(1));
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (longint'(1) << b);
			end
		end
		return quo;
	endfunction

	// tanh(x/2) at x = i*16/N in Q2.16, from integer arithmetic: exp(-d) by a
	// floored Taylor series in Q30, powers by floored Q30 products.
	function automatic tanh_rom_t build_tanh_rom();
		longint   one_q30;
		longint   d;
		longint   term;
		longint   base;
		longint   p;
		longint   den;
		tanh_rom_t rom;
		one_q30 = longint'(1) << 30;
		d = div_pos(longint'(16) << 30, longint'(TANH_TABLE_ENTRIES));
		term = one_q30;
		base = one_q30;
		p = one_q30;
		for (int k = 1; k <= 24; k++) begin
			if (term > 0) begin
				term = div_pos((term * d) >>> 30, longint'(k));
				base = ((k & 1) == 1) ? base - term : base + term;
			end
		end
		for (int i = 0; i <= TANH_TABLE_ENTRIES; i++) begin
			den = one_q30 + p;
			rom[i] = tanh_t'(div_pos((one_q30 - p) * 2 * 65536 + den, 2 * den));
			p = (p * base) >>> 30;
		end
		return rom;
	endfunction

	localparam tanh_rom_t TANH_ROM  = build_tanh_rom();
	localparam tanh_t     TANH_LAST = TANH_ROM[TANH_TABLE_ENTRIES];

endpackage

### hdl/smc_if.sv
// ----------------------------------------------------------------------------
// smc_if
// Valid/ready channels of the sliding mode controller: error samples in,
// drive values out.
// ----------------------------------------------------------------------------
interface smc_sample_if;
	import smc_pkg::*;

	logic valid;
	logic ready;
	err_t error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

interface smc_result_if;
	import smc_pkg::*;

	logic valid;
	logic ready;
	err_t drive_value;
	logic saturated;

	modport source (output valid, output drive_value, output saturated, input ready);
	modport sink (input valid, input drive_value, input saturated, output ready);
endinterface

### hdl/smc_mul.sv
// ----------------------------------------------------------------------------
// smc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module smc_mul (
	input  logic              clk,
	input  smc_pkg::mul_req_t req,
	output smc_pkg::prod_t    prod
);
	import smc_pkg::*;

	// hold the product until the next request
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= prod_t'(req.a) * prod_t'(req.b);
		end
	end

endmodule

### hdl/smc_tanh_rom.sv
// ----------------------------------------------------------------------------
// smc_tanh_rom
// Switching table, one registered read per cycle.
// ----------------------------------------------------------------------------
module smc_tanh_rom (
	input  logic           clk,
	input  smc_pkg::idx_t  addr,
	output smc_pkg::tanh_t data
);
	import smc_pkg::*;

	always_ff @(posedge clk) begin
		data <= TANH_ROM[addr];
	end

endmodule

### hdl/sliding_mode_controller.sv
// ----------------------------------------------------------------------------
// sliding_mode_controller
// Each request carries one tracking error e (signed Q16.16). The block forms
// the error rate ve = e - previous e and the sliding surface
// S = ve + lambda*e, and returns u = -lambda*ve - ks*S - eps*tanh(S/2),
// saturated to the signed 32-bit range with a flag when clipped. tanh(S/2)
// comes from a table with linear interpolation; beyond |S| >= 16.0 the last
// entry is used. Products are floored after their shift; ks times the integer
// part of S is exact and unshifted. One shared 25x34 multiplier under a small
// sequencer does every product, so a request is taken only when the sequencer
// is idle. A finished result waits in the output register while the next
// request is already being worked on. Gains must be written through the cfg
// port only while no request is in flight; the block does not enforce this.
// Reset clears the stored error and loads lambda = ks = 1.0, eps = 0.
// ----------------------------------------------------------------------------
module sliding_mode_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [smc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smc_pkg::GAIN_W-1:0] cfg_data,
	smc_sample_if.sink                 sample,
	smc_result_if.source               result
);
	import smc_pkg::*;

	localparam mul_a_t TABLE_N_A = mul_a_t'(TANH_TABLE_ENTRIES);
	localparam acc_t   U_MAX     = acc_t'(32'sh7FFF_FFFF);
	localparam acc_t   U_MIN     = acc_t'(32'sh8000_0000);

	smc_state_t state_q, state_d;

	// Configuration and carried state
	gain_t slope_q;
	gain_t gain_q;
	gain_t eps_q;
	err_t  prev_err_q;

	// Working registers
	err_t  err_q;
	ve_t   ve_q;
	surf_t s_q;
	surf_t mag_q;
	logic  neg_q;
	logic  big_q;
	acc_t  acc_q;
	idx_t  idx_q;
	frac_t frac_q;
	tanh_t lo_q;
	tanh_t t_q;

	// Output register
	logic  out_valid_q;
	err_t  out_value_q;
	logic  out_sat_q;

	mul_req_t mul_req;
	prod_t    prod;
	idx_t     rom_addr;
	tanh_t    rom_data;

	logic  accept;
	logic  out_load;
	acc_t  prod_sh16;
	acc_t  u_full;
	tanh_t t_interp;
	tanh_t t_abs;

	smc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	smc_tanh_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign result.valid       = out_valid_q;
	assign result.drive_value = out_value_q;
	assign result.saturated   = out_sat_q;

	assign prod_sh16 = acc_t'(prod >>> Q_SHIFT);
	assign t_interp  = lo_q + tanh_t'(prod >>> FRAC_W);
	assign t_abs     = big_q ? TANH_LAST : t_interp;
	assign u_full    = -acc_q;

	// Sequencer: next state, multiplier operands, table address
	always_comb begin
		state_d  = state_q;
		mul_req  = '0;
		rom_addr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL_LE;
				end
			end
			ST_MUL_LE: begin
				mul_req = '{en: 1'b1, a: mul_a_t'({1'b0, slope_q}), b: mul_b_t'(err_q)};
				state_d = ST_MUL_LV;
			end
			ST_MUL_LV: begin
				mul_req = '{en: 1'b1, a: mul_a_t'({1'b0, slope_q}), b: mul_b_t'(ve_q)};
				state_d = ST_MUL_KH;
			end
			ST_MUL_KH: begin
				mul_req = '{en: 1'b1, a: mul_a_t'({1'b0, gain_q}), b: mul_b_t'(s_q >>> Q_SHIFT)};
				state_d = ST_MUL_KL;
			end
			ST_MUL_KL: begin
				mul_req = '{en: 1'b1, a: mul_a_t'({1'b0, gain_q}),
					b: mul_b_t'({1'b0, s_q[Q_SHIFT-1:0]})};
				state_d = ST_MUL_POS;
			end
			ST_MUL_POS: begin
				mul_req = '{en: 1'b1, a: TABLE_N_A, b: mul_b_t'({1'b0, mag_q[FRAC_W-1:0]})};
				state_d = ST_RD_LO;
			end
			ST_RD_LO: begin
				rom_addr = prod[FRAC_W +: IDX_W];
				state_d  = ST_RD_HI;
			end
			ST_RD_HI: begin
				rom_addr = idx_t'(idx_q + 1'b1);
				state_d  = ST_MUL_IP;
			end
			ST_MUL_IP: begin
				mul_req = '{en: 1'b1, a: mul_a_t'(tanh_t'(rom_data - lo_q)),
					b: mul_b_t'({1'b0, frac_q})};
				state_d = ST_SIGN;
			end
			ST_SIGN: begin
				state_d = ST_MUL_ET;
			end
			ST_MUL_ET: begin
				mul_req = '{en: 1'b1, a: mul_a_t'({1'b0, eps_q}), b: mul_b_t'(t_q)};
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Gains and stored error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q    <= SURFACE_SLOPE_RST;
			gain_q     <= SURFACE_GAIN_RST;
			eps_q      <= SWITCHING_GAIN_RST;
			prev_err_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_SURFACE_SLOPE:  slope_q <= cfg_data;
					REG_SURFACE_GAIN:   gain_q  <= cfg_data;
					REG_SWITCHING_GAIN: eps_q   <= cfg_data;
					default: ;  // drop writes to unknown indexes
				endcase
			end
			if (accept) begin
				prev_err_q <= sample.error_sample;
			end
		end
	end

	// Datapath: the accumulator collects lambda*ve + ks*S + eps*tanh, negated at the end
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q <= sample.error_sample;
				ve_q  <= ve_t'(sample.error_sample) - ve_t'(prev_err_q);
			end
			ST_MUL_LV: begin
				s_q <= surf_t'(ve_q) + surf_t'(prod >>> Q_SHIFT);
			end
			ST_MUL_KH: begin
				acc_q <= prod_sh16;
				mag_q <= s_q[S_W-1] ? -s_q : s_q;
				neg_q <= s_q[S_W-1];
			end
			ST_MUL_KL: begin
				// integer part of S times ks is exact, no shift
				acc_q <= acc_q + acc_t'(prod);
				big_q <= |mag_q[S_W-1:FRAC_W];
			end
			ST_MUL_POS: begin
				acc_q <= acc_q + prod_sh16;
			end
			ST_RD_LO: begin
				idx_q  <= prod[FRAC_W +: IDX_W];
				frac_q <= prod[FRAC_W-1:0];
			end
			ST_RD_HI: begin
				lo_q <= rom_data;
			end
			ST_SIGN: begin
				t_q <= neg_q ? -t_abs : t_abs;
			end
			ST_SUM: begin
				acc_q <= acc_q + prod_sh16;
			end
			default: ;
		endcase
	end

	// Output register: hold a result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (u_full > U_MAX) begin
				out_value_q <= U_MAX[ERR_W-1:0];
				out_sat_q   <= 1'b1;
			end else if (u_full < U_MIN) begin
				out_value_q <= U_MIN[ERR_W-1:0];
				out_sat_q   <= 1'b1;
			end else begin
				out_value_q <= u_full[ERR_W-1:0];
				out_sat_q   <= 1'b0;
			end
		end
	end

	// A request keeps the sequencer busy on the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("request accepted but sequencer still idle");

	// A clipped result sits exactly on a limit
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.saturated) |->
			(result.drive_value == U_MAX[ERR_W-1:0] ||
			 result.drive_value == U_MIN[ERR_W-1:0]))
		else $error("saturation flag set off a limit");

	// New results come only from the final sequencer step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the final step");

	// Leaving the final step always loads the output register
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && state_d == ST_IDLE) |=> result.valid)
		else $error("result lost on completion");

endmodule
